// ----- rtl/core/min_heap_insert_and_relation_query_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the min-heap block
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MIN_HEAP_INSERT_AND_RELATION_QUERY_TOP_MACROS_SVH
`define MIN_HEAP_INSERT_AND_RELATION_QUERY_TOP_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define MHIRQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mhirq: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define MHIRQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mhirq: next-cycle check failed");
`else
`define MHIRQ_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define MHIRQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/core/mhirq_pkg.sv -----
// ----------------------------------------------------------------------------
// Min-heap package
// Opcodes and fixed widths shared by the min-heap block.
// ----------------------------------------------------------------------------
package mhirq_pkg;

  localparam int OPCODE_WIDTH = 3;
  localparam int OUT_DATA_W   = 8;

  typedef enum logic [OPCODE_WIDTH-1:0] {
    OP_INSERT  = 3'd0,
    OP_ROOT    = 3'd1,
    OP_SIBLING = 3'd2,
    OP_PARENT  = 3'd3,
    OP_CHILD   = 3'd4
  } opcode_e;

endpackage

// ----- rtl/core/mhirq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mhirq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/min_heap_insert_and_relation_query_top.sv -----
// ----------------------------------------------------------------------------
// Min-heap with insert and relation queries
// Binary min-heap held in a RAM, one shared read/compare step per cycle.
// ----------------------------------------------------------------------------
// Usage:
// Words arrive on the s_axis channel: tuser carries the opcode, tdata the two
// keys. Each word gives one result word on m_axis, the answer in tdata and the
// heap-full flag in tuser. s_axis_tready is high only between words.
// An insert into slot p sifts up at most floor(log2(p)) levels, each a parent
// read (ST_SIFT_RD) and then a compare and write (ST_SIFT_CMP).
// A query scans the n stored keys through the one RAM read port, a key per
// cycle, then evaluates the relation (ST_EVAL) and loads its result (ST_DONE).
// The next word is taken in the cycle after a result is loaded, so no word is
// taken while one is in work and the scan of a full heap sets the worst rate.
// If the receiver stalls, a finished result waits until the output register
// is free. Reset clears the entry count; slots are only read below the count.
// ----------------------------------------------------------------------------
module min_heap_insert_and_relation_query_top #(
  parameter int  HEAP_DEPTH = 1024,
  parameter int  KEY_WIDTH  = 16,
  localparam int IN_DATA_W  = ((2 * KEY_WIDTH + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // key_a, key_b (from the lowest bit up), zero padded
  input  logic [IN_DATA_W-1:0]                s_axis_tdata,
  // opcode
  input  logic [mhirq_pkg::OPCODE_WIDTH-1:0]  s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // answer, zero padded
  output logic [mhirq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status
  output logic                                m_axis_tuser
);

  `include "min_heap_insert_and_relation_query_top_macros.svh"

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int PW = $clog2(HEAP_DEPTH + 2);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SIFT_RD  = 6'b000010,
    ST_SIFT_CMP = 6'b000100,
    ST_SCAN     = 6'b001000,
    ST_EVAL     = 6'b010000,
    ST_DONE     = 6'b100000
  } state_e;

  state_e                    state_q, state_d;
  mhirq_pkg::opcode_e        op_q, op_d;
  mhirq_pkg::opcode_e        in_op;
  logic signed [KEY_WIDTH-1:0] key_a_q, key_a_d;
  logic signed [KEY_WIDTH-1:0] key_b_q, key_b_d;
  logic [PW-1:0]             count_q, count_d;
  logic [PW-1:0]             pos_q, pos_d;
  logic                      rd_vld_q, rd_vld_d;
  logic [PW-1:0]             rd_pos_q, rd_pos_d;
  logic [PW-1:0]             pa_q, pa_d;
  logic [PW-1:0]             pb_q, pb_d;
  logic                      ans_q, ans_d;
  logic                      sts_q, sts_d;
  logic                      m_valid_q, m_valid_d;
  logic                      m_answer_q, m_answer_d;
  logic                      m_status_q, m_status_d;

  logic                      ram_we;
  logic                      ram_re;
  logic [AW-1:0]             ram_waddr;
  logic [AW-1:0]             ram_raddr;
  logic [KEY_WIDTH-1:0]      ram_wdata;
  logic [KEY_WIDTH-1:0]      ram_rdata;
  logic signed [KEY_WIDTH-1:0] rd_key;
  logic [PW-1:0]             pos_m1;
  logic [PW-1:0]             parent_m1;

  assign in_op     = mhirq_pkg::opcode_e'(s_axis_tuser);
  assign rd_key    = $signed(ram_rdata);
  // Heap positions start at 1, RAM addresses at 0.
  assign pos_m1    = pos_q - PW'(1);
  assign parent_m1 = (pos_q >> 1) - PW'(1);

  mhirq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (HEAP_DEPTH)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_a_d    = key_a_q;
    key_b_d    = key_b_q;
    count_d    = count_q;
    pos_d      = pos_q;
    rd_vld_d   = 1'b0;
    rd_pos_d   = rd_pos_q;
    pa_d       = pa_q;
    pb_d       = pb_q;
    ans_d      = ans_q;
    sts_d      = sts_q;
    m_answer_d = m_answer_q;
    m_status_d = m_status_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = pos_m1[AW-1:0];
    ram_wdata  = key_a_q;
    ram_raddr  = pos_m1[AW-1:0];

    // Scan data returns in the cycle after its read; later matches win.
    if (rd_vld_q) begin
      if (rd_key == key_a_q) begin
        pa_d = rd_pos_q;
      end
      if (rd_key == key_b_q) begin
        pb_d = rd_pos_q;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = in_op;
          key_a_d = $signed(s_axis_tdata[KEY_WIDTH-1:0]);
          key_b_d = $signed(s_axis_tdata[2*KEY_WIDTH-1:KEY_WIDTH]);
          pa_d    = '0;
          pb_d    = '0;
          ans_d   = 1'b0;
          sts_d   = 1'b0;
          case (in_op) inside
            mhirq_pkg::OP_INSERT: begin
              if (count_q == PW'(HEAP_DEPTH)) begin
                sts_d   = 1'b1;
                state_d = ST_DONE;
              end else begin
                count_d = count_q + PW'(1);
                pos_d   = count_q + PW'(1);
                state_d = ST_SIFT_RD;
              end
            end
            mhirq_pkg::OP_ROOT, mhirq_pkg::OP_SIBLING,
            mhirq_pkg::OP_PARENT, mhirq_pkg::OP_CHILD: begin
              pos_d   = PW'(1);
              state_d = ST_SCAN;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_SIFT_RD: begin
        if (pos_q > PW'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = parent_m1[AW-1:0];
          state_d   = ST_SIFT_CMP;
        end else begin
          ram_we  = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_SIFT_CMP: begin
        ram_we = 1'b1;
        if (key_a_q < rd_key) begin
          // Parent moves down into the hole; the hole moves up.
          ram_wdata = ram_rdata;
          pos_d     = pos_q >> 1;
          state_d   = ST_SIFT_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (pos_q <= count_q) begin
          ram_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_pos_d = pos_q;
          pos_d    = pos_q + PW'(1);
        end else if (!rd_vld_q) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        case (op_q)
          mhirq_pkg::OP_ROOT:    ans_d = (pa_q == PW'(1));
          mhirq_pkg::OP_SIBLING: ans_d = ((pa_q >> 1) == (pb_q >> 1));
          mhirq_pkg::OP_PARENT:  ans_d = ((pb_q >> 1) == pa_q);
          mhirq_pkg::OP_CHILD:   ans_d = ((pa_q >> 1) == pb_q);
          default:               ans_d = 1'b0;
        endcase
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_answer_d = ans_q;
          m_status_d = sts_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= mhirq_pkg::OP_INSERT;
      count_q   <= '0;
      pos_q     <= '0;
      rd_vld_q  <= 1'b0;
      ans_q     <= 1'b0;
      sts_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      rd_vld_q  <= rd_vld_d;
      ans_q     <= ans_d;
      sts_q     <= sts_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_a_q    <= key_a_d;
    key_b_q    <= key_b_d;
    rd_pos_q   <= rd_pos_d;
    pa_q       <= pa_d;
    pb_q       <= pb_d;
    m_answer_q <= m_answer_d;
    m_status_q <= m_status_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(mhirq_pkg::OUT_DATA_W - 1){1'b0}}, m_answer_q};
  assign m_axis_tuser  = m_status_q;

  `MHIRQ_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= PW'(HEAP_DEPTH))
  `MHIRQ_ASSERT_NEXT(a_count_only_on_accept, clk_i, rst_ni, state_q != ST_IDLE, $stable(count_q))
  `MHIRQ_ASSERT_NOW(a_scan_in_range, clk_i, rst_ni, rd_vld_q, (rd_pos_q != '0) && (rd_pos_q <= count_q))
  `MHIRQ_ASSERT_NOW(a_sift_has_parent, clk_i, rst_ni, state_q == ST_SIFT_CMP, pos_q > PW'(1))

endmodule

// ----- dv/min_heap_insert_and_relation_query_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Min-heap insert and relation query testbench
// Streams insert and query words into the heap, keeps a shadow heap that
// predicts answers and full flags, and checks each result word with it or its row.
// A directed table opens the run, random traffic grows the heap to a few
// hundred keys, and a closing stretch without gaps queries its deep end.
// ----------------------------------------------------------------------------
module min_heap_insert_and_relation_query_top_tb;

  localparam int HEAP_DEPTH  = 1024;
  localparam int KEY_WIDTH   = 16;
  localparam int IN_DATA_W   = ((2 * KEY_WIDTH + 7) / 8) * 8;
  localparam int RANDOM_WORDS = 546;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 64;

  typedef logic [mhirq_pkg::OPCODE_WIDTH-1:0] opcode_t;

  // Opcodes the block leaves without effect.
  localparam opcode_t OP_UNUSED_LO  = 3'd5;
  localparam opcode_t OP_UNUSED_MID = 3'd6;
  localparam opcode_t OP_UNUSED_HI  = 3'd7;

  localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = 16'sh7fff;
  localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = 16'sh8000;

  typedef logic signed [KEY_WIDTH-1:0] key_t;

  typedef struct packed {
    logic answer;
    logic status;
  } heap_result_t;

  typedef struct packed {
    opcode_t op;
    key_t    key_a;
    key_t    key_b;
    logic    known;
    logic    answer;
    logic    status;
  } table_row_t;

  localparam int TABLE_ROWS = 22;
  // Rows with known set carry a result that is plain from the heap contents.
  localparam table_row_t DIRECTED_ROWS [TABLE_ROWS] = '{
    '{mhirq_pkg::OP_ROOT,    16'sd0,    16'sd0,     1'b1, 1'b0, 1'b0},
    '{mhirq_pkg::OP_SIBLING, 16'sd0,    16'sd5,     1'b1, 1'b1, 1'b0},
    '{mhirq_pkg::OP_PARENT,  16'sd0,    16'sd0,     1'b1, 1'b1, 1'b0},
    '{mhirq_pkg::OP_CHILD,   -16'sd1,   16'sd7,     1'b1, 1'b1, 1'b0},
    '{OP_UNUSED_HI,          -16'sd1,   -16'sd1,    1'b1, 1'b0, 1'b0},
    '{mhirq_pkg::OP_INSERT,  KEY_MAX,   KEY_MIN,    1'b1, 1'b0, 1'b0},
    '{mhirq_pkg::OP_ROOT,    KEY_MAX,   16'sd3,     1'b1, 1'b1, 1'b0},
    '{mhirq_pkg::OP_INSERT,  KEY_MIN,   KEY_MAX,    1'b1, 1'b0, 1'b0},
    '{mhirq_pkg::OP_INSERT,  16'sd0,    -16'sd1,    1'b1, 1'b0, 1'b0},
    '{mhirq_pkg::OP_ROOT,    KEY_MIN,   16'sd12345, 1'b1, 1'b1, 1'b0},
    '{mhirq_pkg::OP_SIBLING, KEY_MAX,   16'sd0,     1'b0, 1'b0, 1'b0},
    '{mhirq_pkg::OP_SIBLING, KEY_MIN,   16'sd99,    1'b0, 1'b0, 1'b0},
    '{mhirq_pkg::OP_PARENT,  KEY_MIN,   16'sd0,     1'b0, 1'b0, 1'b0},
    '{mhirq_pkg::OP_CHILD,   KEY_MAX,   KEY_MIN,    1'b0, 1'b0, 1'b0},
    '{mhirq_pkg::OP_CHILD,   KEY_MIN,   KEY_MAX,    1'b0, 1'b0, 1'b0},
    '{mhirq_pkg::OP_INSERT,  16'sd0,    16'sd0,     1'b0, 1'b0, 1'b0},
    '{mhirq_pkg::OP_INSERT,  -16'sd1,   16'sh5555,  1'b0, 1'b0, 1'b0},
    '{mhirq_pkg::OP_PARENT,  16'sd0,    -16'sd1,    1'b0, 1'b0, 1'b0},
    '{OP_UNUSED_LO,          16'sd0,    16'sd0,     1'b1, 1'b0, 1'b0},
    '{OP_UNUSED_MID,         KEY_MAX,   KEY_MIN,    1'b1, 1'b0, 1'b0},
    '{mhirq_pkg::OP_INSERT,  16'sh2aaa, -16'sh2aab, 1'b0, 1'b0, 1'b0},
    '{mhirq_pkg::OP_SIBLING, 16'sd0,    16'sd0,     1'b0, 1'b0, 1'b0}
  };

  logic                               clk_i         = 1'b0;
  logic                               rst_ni        = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [IN_DATA_W-1:0]               s_axis_tdata  = '0;
  opcode_t                            s_axis_tuser  = '0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [mhirq_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
  logic                               m_axis_tuser;

  // Shadow heap, positions 1..heap_fill are the filled ones.
  key_t         heap_keys [1:HEAP_DEPTH];
  int unsigned  heap_fill;
  heap_result_t answers_due [$];

  bit          quiet;
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned words_checked;
  int unsigned n_inserts, n_dropped, n_queries, n_true;

  min_heap_insert_and_relation_query_top #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending",
               cycle_count, answers_due.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    err_count++;
  endtask

  // Highest filled position holding the key, 0 when absent.
  function automatic int unsigned key_position(input key_t k);
    int unsigned found;
    found = 0;
    for (int unsigned p = 1; p <= heap_fill; p++) begin
      if (heap_keys[p] == k) begin
        found = p;
      end
    end
    return found;
  endfunction

  // Applies one word to the shadow heap and returns the result it gives.
  function automatic heap_result_t apply_heap_word(input opcode_t op,
                                                   input key_t ka, input key_t kb);
    heap_result_t res;
    int unsigned  pa, pb, slot;
    res  = '0;
    pa   = key_position(ka);
    pb   = key_position(kb);
    case (op)
      mhirq_pkg::OP_INSERT: begin
        if (heap_fill >= HEAP_DEPTH) begin
          res.status = 1'b1;
        end else begin
          heap_fill++;
          slot = heap_fill;
          while (slot > 1 && ka < heap_keys[slot / 2]) begin
            heap_keys[slot] = heap_keys[slot / 2];
            slot = slot / 2;
          end
          heap_keys[slot] = ka;
        end
      end
      mhirq_pkg::OP_ROOT:    res.answer = (pa == 1);
      mhirq_pkg::OP_SIBLING: res.answer = (pa / 2 == pb / 2);
      mhirq_pkg::OP_PARENT:  res.answer = (pb / 2 == pa);
      mhirq_pkg::OP_CHILD:   res.answer = (pa / 2 == pb);
      default:               res = '0;
    endcase
    return res;
  endfunction

  function automatic key_t random_key();
    key_t k;
    case ($urandom_range(0, 5))
      0, 1:    k = key_t'($urandom_range(0, 16)) - 16'sd8;
      2:       k = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
      3:       k = (heap_fill > 0) ? heap_keys[$urandom_range(1, heap_fill)] : key_t'($urandom);
      default: k = key_t'($urandom);
    endcase
    return k;
  endfunction

  // Mostly picks keys that stand in a relation inside the heap.
  task automatic pick_query_keys(output key_t ka, output key_t kb);
    int unsigned p, q;
    p = 0;
    if (heap_fill == 0 || $urandom_range(0, 9) == 0) begin
      ka = random_key();
    end else begin
      p  = $urandom_range(1, heap_fill);
      ka = heap_keys[p];
    end
    case ($urandom_range(0, 6))
      0:       q = 2 * p;
      1:       q = 2 * p + 1;
      2:       q = p / 2;
      3:       q = p ^ 1;
      4:       q = (heap_fill > 0) ? $urandom_range(1, heap_fill) : 0;
      default: q = 0;
    endcase
    kb = (q >= 1 && q <= heap_fill) ? heap_keys[q] : random_key();
  endtask

  function automatic opcode_t random_query_op();
    return opcode_t'($urandom_range(mhirq_pkg::OP_ROOT, mhirq_pkg::OP_CHILD));
  endfunction

  task automatic send_word(input opcode_t op, input key_t ka,
                           input key_t kb, input logic known = 1'b0,
                           input heap_result_t known_res = '0);
    heap_result_t res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {kb, ka};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    res = apply_heap_word(op, ka, kb);
    if (op == mhirq_pkg::OP_INSERT) begin
      n_inserts++;
      n_dropped += 32'(res.status);
    end else if (op <= mhirq_pkg::OP_CHILD) begin
      n_queries++;
      n_true += 32'(res.answer);
    end
    answers_due.push_back(known ? known_res : res);
  endtask

  // Result side: random stalls, check of every accepted result word.
  initial begin
    heap_result_t want;
    int unsigned  stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        words_checked++;
        if (answers_due.size() == 0) begin
          flag_mismatch($sformatf("result word with nothing pending (tdata %h tuser %b)",
                                  m_axis_tdata, m_axis_tuser));
        end else begin
          want = answers_due.pop_front();
          if (m_axis_tdata !== {{(mhirq_pkg::OUT_DATA_W - 1){1'b0}}, want.answer}) begin
            flag_mismatch($sformatf("word %0d answer: got tdata %h, want %b",
                                    words_checked, m_axis_tdata, want.answer));
          end
          if (m_axis_tuser !== want.status) begin
            flag_mismatch($sformatf("word %0d status: got %b, want %b",
                                    words_checked, m_axis_tuser, want.status));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned  sent;
    int unsigned  roll;
    key_t         ka, kb;
    heap_result_t typed_res;

    heap_fill = 0;
    quiet     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < TABLE_ROWS; i++) begin
      typed_res = '{answer: DIRECTED_ROWS[i].answer, status: DIRECTED_ROWS[i].status};
      send_word(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].key_a, DIRECTED_ROWS[i].key_b,
                DIRECTED_ROWS[i].known, typed_res);
    end

    // Random traffic; the heap grows to a few hundred keys.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        send_word(opcode_t'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), key_t'($urandom),
                  key_t'($urandom));
      end else if (roll < 40) begin
        send_word(mhirq_pkg::OP_INSERT, random_key(), key_t'($urandom));
      end else begin
        pick_query_keys(ka, kb);
        send_word(random_query_op(), ka, kb);
      end
      sent++;
    end

    // Last stretch runs without gaps on either side.
    quiet = 1'b1;
    for (int i = 0; i < 3; i++) begin
      send_word(mhirq_pkg::OP_INSERT, random_key(), key_t'($urandom));
    end
    send_word(mhirq_pkg::OP_ROOT, heap_keys[1], key_t'($urandom));
    send_word(mhirq_pkg::OP_PARENT, heap_keys[heap_fill / 2], heap_keys[heap_fill]);
    send_word(mhirq_pkg::OP_CHILD, heap_keys[heap_fill], heap_keys[heap_fill / 2]);
    send_word(mhirq_pkg::OP_SIBLING, heap_keys[heap_fill - 1], heap_keys[heap_fill]);
    for (int i = 0; i < 4; i++) begin
      pick_query_keys(ka, kb);
      send_word(random_query_op(), ka, kb);
    end
    send_word(mhirq_pkg::OP_INSERT, KEY_MIN, KEY_MAX);
    s_axis_tvalid <= 1'b0;

    while (answers_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d inserts (%0d dropped on a full heap) and %0d relation queries, %0d true.",
             n_inserts, n_dropped, n_queries, n_true);
    $display("Heap held %0d of %0d keys at the end; %0d result words checked, %0d errors.",
             heap_fill, HEAP_DEPTH, words_checked, err_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- min_heap_insert_and_relation_query_top.f -----
+incdir+rtl/core
rtl/core/mhirq_pkg.sv
rtl/core/mhirq_ram.sv
rtl/core/min_heap_insert_and_relation_query_top.sv
dv/min_heap_insert_and_relation_query_top_tb.sv
